[hdl/ows_pkg.sv]
// Shared item types and fixed codes for the one-wire temperature sequencer.
`timescale 1ns / 1ps

package ows_pkg;

    // Input item: a timer tick or a completed UART slot with its echo.
    typedef struct packed {
        logic       kind;
        logic [7:0] echo_byte;
    } t_item;

    // Result item: a slot command or a temperature reading.
    typedef struct packed {
        logic        out_kind;
        logic        slow_baud;
        logic [7:0]  tx_byte;
        logic [11:0] temperature;
        logic        last;
    } t_res;

    // Results raised by one input item, at most two, in delivery order.
    typedef struct packed {
        logic valid0;
        logic valid1;
        t_res res0;
        t_res res1;
    } t_push;

    // Input item kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Result item kinds.
    localparam logic OUT_SLOT = 1'b0;
    localparam logic OUT_TEMP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_WAIT_TICKS = 1'b0;

    // Reset value of the wait length register.
    localparam logic [7:0] WAIT_TICKS_RESET = 8'd2;

endpackage

[hdl/ows_apb.sv]
// APB-style configuration register holding the conversion wait length.
`timescale 1ns / 1ps

module ows_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_wait_ticks
);

    logic [7:0] r_wait_ticks;
    logic       w_write;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    // Register write on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= ows_pkg::WAIT_TICKS_RESET;
        end else if (w_write && paddr[2] == ows_pkg::REG_WAIT_TICKS) begin
            r_wait_ticks <= pwdata[7:0];
        end
    end

    // Read back; addresses beyond the register read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == ows_pkg::REG_WAIT_TICKS) begin
            prdata = {24'd0, r_wait_ticks};
        end
    end

    assign o_wait_ticks = r_wait_ticks;

endmodule

[hdl/ows_step.sv]
// Bus sequencing state and the per-item next-state and result logic.
`timescale 1ns / 1ps

module ows_step #(
    parameter int READ_BYTES = 9,
    parameter int TEMP_BITS  = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  ows_pkg::t_item      i_item,
    input  logic [7:0]          i_wait_ticks,
    output ows_pkg::t_push      o_push
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PREP = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_READ = 4'b1000
    } t_phase;

    // Slot layout: reset, eight skip-ROM bits, eight function bits, then reads.
    localparam logic [6:0]  CMD_END  = 7'd17;
    localparam logic [6:0]  READ_END = 7'(17 + 8 * READ_BYTES);
    localparam logic [6:0]  KEEP_END = 7'd33;
    localparam logic [6:0]  ROM_LAST = 7'd8;
    localparam logic [15:0] TEMP_MASK = 16'((17'd1 << TEMP_BITS) - 17'd1);

    localparam logic [7:0] TX_RESET  = 8'hF0;
    localparam logic [7:0] SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CONVERT   = 8'h44;
    localparam logic [7:0] READ_PAD  = 8'hBE;
    localparam logic [7:0] TX_ONE    = 8'hFF;
    localparam logic [7:0] TX_ZERO   = 8'h00;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_idx, n_idx;
    logic        r_out, n_out;
    logic [7:0]  r_wcount, n_wcount;
    logic [15:0] r_shift, n_shift;
    logic [6:0]  w_idx_inc;
    logic [3:0]  w_bitpos;

    // Slot command for a given phase and slot position.
    function automatic ows_pkg::t_res slot_cmd(input logic is_prep, input logic [6:0] idx);
        logic [7:0]    cmd;
        logic [2:0]    pos;
        ows_pkg::t_res r;
        r          = '0;
        r.out_kind = ows_pkg::OUT_SLOT;
        r.last     = 1'b1;
        r.tx_byte  = TX_ONE;
        pos        = 3'(idx - 7'd1);
        if (idx == 7'd0 || (!is_prep && idx == READ_END)) begin
            r.slow_baud = 1'b1;
            r.tx_byte   = TX_RESET;
        end else if (idx < CMD_END) begin
            cmd       = (idx <= ROM_LAST) ? SKIP_ROM : (is_prep ? CONVERT : READ_PAD);
            r.tx_byte = cmd[pos] ? TX_ONE : TX_ZERO;
        end
        return r;
    endfunction

    assign w_idx_inc = r_idx + 7'd1;
    assign w_bitpos  = 4'(r_idx - CMD_END);

    // Next state and results for the item taken this cycle.
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_out    = r_out;
        n_wcount = r_wcount;
        n_shift  = r_shift;
        o_push   = '0;
        if (i_take) begin
            if (i_item.kind == ows_pkg::KIND_TICK) begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase     = PH_PREP;
                        n_idx       = '0;
                        n_out       = 1'b1;
                        o_push.valid0 = 1'b1;
                        o_push.res0 = slot_cmd(1'b1, 7'd0);
                    end
                    PH_WAIT: begin
                        n_wcount = (r_wcount == 8'hFF) ? r_wcount : r_wcount + 8'd1;
                        if (n_wcount >= i_wait_ticks) begin
                            n_phase       = PH_READ;
                            n_idx         = '0;
                            n_shift       = '0;
                            n_out         = 1'b1;
                            o_push.valid0 = 1'b1;
                            o_push.res0   = slot_cmd(1'b0, 7'd0);
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (r_out) begin
                n_out = 1'b0;
                unique case (r_phase)
                    PH_PREP: begin
                        if (w_idx_inc >= CMD_END) begin
                            n_phase  = PH_WAIT;
                            n_idx    = '0;
                            n_wcount = '0;
                        end else begin
                            n_idx         = w_idx_inc;
                            n_out         = 1'b1;
                            o_push.valid0 = 1'b1;
                            o_push.res0   = slot_cmd(1'b1, w_idx_inc);
                        end
                    end
                    PH_READ: begin
                        // Keep the first sixteen read bits; only an exact 0xFF echo is a one.
                        if (r_idx >= CMD_END && r_idx < READ_END && r_idx < KEEP_END
                                && i_item.echo_byte == TX_ONE) begin
                            n_shift[w_bitpos] = 1'b1;
                        end
                        if (r_idx >= READ_END) begin
                            n_phase       = PH_PREP;
                            n_idx         = '0;
                            n_out         = 1'b1;
                            o_push.valid0 = 1'b1;
                            o_push.res0   = slot_cmd(1'b1, 7'd0);
                        end else begin
                            n_idx         = w_idx_inc;
                            n_out         = 1'b1;
                            o_push.valid0 = 1'b1;
                            if (w_idx_inc == READ_END) begin
                                o_push.valid1 = 1'b1;
                                o_push.res0   = '0;
                                o_push.res0.out_kind    = ows_pkg::OUT_TEMP;
                                o_push.res0.temperature = n_shift[11:0] & TEMP_MASK[11:0];
                                o_push.res1   = slot_cmd(1'b0, w_idx_inc);
                            end else begin
                                o_push.res0   = slot_cmd(1'b0, w_idx_inc);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_out    <= 1'b0;
            r_wcount <= '0;
            r_shift  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_out    <= n_out;
            r_wcount <= n_wcount;
            r_shift  <= n_shift;
        end
    end

`ifndef SYNTHESIS
    // No slot is ever in flight during the conversion wait.
    a_wait_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out && r_phase == PH_WAIT))
        else $error("slot outstanding while waiting");

    // A pair of results only arises at the end of the read slots.
    a_pair_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid1 |-> (o_push.valid0 && r_phase == PH_READ && r_out))
        else $error("result pair outside read phase");

    // Once started, the sequencer never returns to idle.
    a_no_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |=> (r_phase != PH_IDLE))
        else $error("sequencer fell back to idle");
`endif

endmodule

[hdl/ows_outq.sv]
// Four-entry result queue that decouples the sequencer from the output channel.
`timescale 1ns / 1ps

module ows_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ows_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output ows_pkg::t_res  o_res
);

    ows_pkg::t_res r_mem [4];
    logic [1:0]    r_wr;
    logic [1:0]    r_rd;
    logic [2:0]    r_count;
    logic [1:0]    w_npush;
    logic          w_pop;

    // An item may be taken whenever two results would still fit.
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;
    assign w_npush = {1'b0, i_push.valid0} + {1'b0, i_push.valid1};

    // Result storage, written in order at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + w_npush;
            r_rd    <= r_rd + {1'b0, w_pop};
            r_count <= r_count + {1'b0, w_npush} - {2'b00, w_pop};
        end
    end

`ifndef SYNTHESIS
    // The queue never overflows.
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // A delivered result with nothing pushed lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_npush == 2'd0) |=> (r_count == $past(r_count) - 3'd1))
        else $error("result queue count slip");
`endif

endmodule

[hdl/one_wire_temperature_sequencer.sv]
// Top level of the one-wire temperature sequencer driving the bus through UART slots.
//
//   channel   direction  handshake               payload
//   input     in         i_in_valid/o_in_ready   i_in_item  (ows_pkg::t_item)
//   result    out        o_out_valid/i_out_ready o_out_item (ows_pkg::t_res)
//   config    in         psel/penable/pready     paddr, pwdata, prdata
//
// An item is taken in every cycle while the four-entry result queue has room
// for two results; each item is handled in the cycle it is taken.
// A result can leave the cycle after its item was taken; the queue sets the stall behaviour.
// Synchronous active-low reset puts the sequencer in idle and empties the queue.
// A stalled result channel stops intake once the queue holds three results.
`timescale 1ns / 1ps

module one_wire_temperature_sequencer #(
    parameter int READ_BYTES = 9,
    parameter int TEMP_BITS  = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ows_pkg::t_item i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ows_pkg::t_res  o_out_item,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic           w_take;
    logic           w_room;
    logic [7:0]     w_wait_ticks;
    ows_pkg::t_push w_push;

    assign o_in_ready = w_room;
    assign w_take     = i_in_valid && w_room;

    // Configuration register.
    ows_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_wait_ticks (w_wait_ticks)
    );

    // Sequencer state and per-item logic.
    ows_step #(
        .READ_BYTES (READ_BYTES),
        .TEMP_BITS  (TEMP_BITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_item       (i_in_item),
        .i_wait_ticks (w_wait_ticks),
        .o_push       (w_push)
    );

    // Result queue towards the output channel.
    ows_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_item)
    );

endmodule

[verif/one_wire_temperature_sequencer_tb.sv]
// Self-checking testbench for the one-wire temperature sequencer with its own behavioural predictor.
`timescale 1ns / 1ps

module one_wire_temperature_sequencer_tb;

    // Bus bytes and 1-Wire command codes.
    localparam logic [7:0] TX_RESET     = 8'hF0;
    localparam logic [7:0] TX_ZERO      = 8'h00;
    localparam logic [7:0] TX_ONE       = 8'hFF;
    localparam logic [7:0] ECHO_ONE     = 8'hFF;
    localparam logic [7:0] ROM_SKIP     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // Slot layout of one cycle.
    localparam int READ_BYTES = 9;
    localparam int TEMP_BITS  = 12;
    localparam int CMD_SLOTS  = 17;
    localparam int READ_END   = CMD_SLOTS + 8 * READ_BYTES;

    localparam logic [2:0] ADDR_WAIT_TICKS = 3'(4 * ows_pkg::REG_WAIT_TICKS);

    localparam ows_pkg::t_res RESET_SLOT = '{out_kind: ows_pkg::OUT_SLOT, slow_baud: 1'b1,
                                             tx_byte: TX_RESET, temperature: 12'd0,
                                             last: 1'b1};
    localparam ows_pkg::t_res NO_RES = '0;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_PREP, SEQ_WAIT, SEQ_READ} t_seq_phase;

    // One row of the directed script; typed rows carry their result by hand.
    typedef struct {
        logic          kind;
        logic [7:0]    echo;
        int            reps;
        bit            typed;
        int            n;
        ows_pkg::t_res res;
    } t_row;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    ows_pkg::t_item i_in_item = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    ows_pkg::t_res o_out_item;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [2:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // Predictor state.
    t_seq_phase    seq_phase   = SEQ_IDLE;
    logic [6:0]    slot_no     = '0;
    logic          slot_busy   = 1'b0;
    logic [7:0]    ticks_seen  = '0;
    logic [15:0]   scratch_bits = '0;
    logic [7:0]    wait_len    = ows_pkg::WAIT_TICKS_RESET;
    ows_pkg::t_res pred_res [2];
    int            pred_n;

    ows_pkg::t_res expected_results [$];
    int   fail_count     = 0;
    int   results_seen   = 0;
    bit   long_hold_done = 1'b0;
    int   hold_left      = 0;
    int   rx_cycle       = 0;
    bit   tx_calm        = 1'b0;

    t_row script [10];

    one_wire_temperature_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // Idle lengths: mostly none, some short, a few long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Appends the slot command for the current phase and slot number.
    task automatic add_slot_command();
        ows_pkg::t_res r;
        logic [7:0]    cmd;
        logic [6:0]    pos;
        r = '0;
        r.out_kind = ows_pkg::OUT_SLOT;
        r.last     = 1'b1;
        r.tx_byte  = TX_ONE;
        if (slot_no == 7'd0 || (seq_phase == SEQ_READ && slot_no == READ_END)) begin
            r.slow_baud = 1'b1;
            r.tx_byte   = TX_RESET;
        end else if (slot_no < CMD_SLOTS) begin
            if (slot_no <= 7'd8) begin
                cmd = ROM_SKIP;
            end else begin
                cmd = (seq_phase == SEQ_PREP) ? CMD_CONVERT : CMD_READ_PAD;
            end
            pos = slot_no - 7'd1;
            r.tx_byte = cmd[pos[2:0]] ? TX_ONE : TX_ZERO;
        end
        slot_busy = 1'b1;
        pred_res[pred_n] = r;
        pred_n++;
    endtask

    // Advances the sequencer state by one accepted item and collects its results.
    task automatic predict_item(input ows_pkg::t_item it);
        ows_pkg::t_res temp_res;
        int            bit_no;
        pred_n = 0;
        if (it.kind == ows_pkg::KIND_TICK) begin
            if (seq_phase == SEQ_IDLE) begin
                seq_phase = SEQ_PREP;
                slot_no   = '0;
                add_slot_command();
            end else if (seq_phase == SEQ_WAIT) begin
                if (ticks_seen != 8'd255) ticks_seen++;
                if (ticks_seen >= wait_len) begin
                    seq_phase    = SEQ_READ;
                    slot_no      = '0;
                    scratch_bits = '0;
                    add_slot_command();
                end
            end
        end else if (slot_busy) begin
            slot_busy = 1'b0;
            if (seq_phase == SEQ_PREP) begin
                slot_no++;
                if (slot_no >= CMD_SLOTS) begin
                    seq_phase  = SEQ_WAIT;
                    slot_no    = '0;
                    ticks_seen = '0;
                end else begin
                    add_slot_command();
                end
            end else if (seq_phase == SEQ_READ) begin
                bit_no = int'(slot_no) - CMD_SLOTS;
                if (bit_no >= 0 && bit_no < 16 && it.echo_byte == ECHO_ONE) begin
                    scratch_bits[bit_no] = 1'b1;
                end
                if (slot_no >= READ_END) begin
                    // Closing reset done: the next cycle starts at once.
                    seq_phase = SEQ_PREP;
                    slot_no   = '0;
                    add_slot_command();
                end else begin
                    slot_no++;
                    if (slot_no == READ_END) begin
                        temp_res             = '0;
                        temp_res.out_kind    = ows_pkg::OUT_TEMP;
                        temp_res.temperature = scratch_bits[TEMP_BITS-1:0];
                        pred_res[pred_n]     = temp_res;
                        pred_n++;
                    end
                    add_slot_command();
                end
            end
        end
    endtask

    task automatic push_predicted();
        for (int k = 0; k < pred_n; k++) expected_results.push_back(pred_res[k]);
    endtask

    // Offers one item, holds it until accepted, then runs the predictor on it.
    task automatic offer_item(input ows_pkg::t_item it, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(it);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_wait_ticks(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WAIT_TICKS;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wait_len = value;
    endtask

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        fail_count++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        ows_pkg::t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, got %h", $time, o_out_item);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.out_kind !== want.out_kind)
                    note_mismatch("out_kind", want.out_kind, o_out_item.out_kind);
                if (o_out_item.slow_baud !== want.slow_baud)
                    note_mismatch("slow_baud", want.slow_baud, o_out_item.slow_baud);
                if (o_out_item.tx_byte !== want.tx_byte)
                    note_mismatch("tx_byte", want.tx_byte, o_out_item.tx_byte);
                if (o_out_item.temperature !== want.temperature)
                    note_mismatch("temperature", want.temperature, o_out_item.temperature);
                if (o_out_item.last !== want.last)
                    note_mismatch("last", want.last, o_out_item.last);
            end
        end
    end

    // Result receiver: random stalls, calm stretches, and one long hold-off.
    always @(posedge i_clk) begin : result_sink
        if (!long_hold_done && results_seen >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_cycle % 1500 >= 400 && $urandom_range(0, 99) < 30) hold_left = draw_gap();
        end
        rx_cycle++;
    end

    // Stimulus: directed script, then random phases under several wait lengths.
    initial begin : stimulus
        ows_pkg::t_item it;
        int             quota;
        int             sent;
        int             r;
        logic [7:0]     wait_settings [8];

        wait_settings = '{8'd255, 8'd1, 8'd3, 8'd128, 8'd1, 8'd8, 8'd2, 8'd17};

        // Directed script, run under the reset wait length of two ticks.
        script[0] = '{ows_pkg::KIND_DONE, 8'hFF, 1, 1'b1, 0, NO_RES};      // stray completion
        script[1] = '{ows_pkg::KIND_TICK, 8'h00, 1, 1'b1, 1, RESET_SLOT};  // start from idle
        script[2] = '{ows_pkg::KIND_TICK, 8'hFF, 1, 1'b1, 0, NO_RES};      // tick while busy
        script[3] = '{ows_pkg::KIND_DONE, 8'h00, 5, 1'b0, 0, NO_RES};
        script[4] = '{ows_pkg::KIND_DONE, 8'hFF, 5, 1'b0, 0, NO_RES};
        script[5] = '{ows_pkg::KIND_DONE, 8'h80, 3, 1'b0, 0, NO_RES};
        script[6] = '{ows_pkg::KIND_DONE, 8'h01, 4, 1'b0, 0, NO_RES};      // last one ends prep
        script[7] = '{ows_pkg::KIND_DONE, 8'hFF, 1, 1'b1, 0, NO_RES};      // stray while waiting
        script[8] = '{ows_pkg::KIND_TICK, 8'h00, 1, 1'b0, 0, NO_RES};
        script[9] = '{ows_pkg::KIND_TICK, 8'hFF, 1, 1'b1, 1, RESET_SLOT};  // wait over

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            for (int k = 0; k < script[i].reps; k++) begin
                it.kind      = script[i].kind;
                it.echo_byte = script[i].echo;
                offer_item(it, draw_gap());
                if (script[i].typed) begin
                    if (script[i].n == 1) expected_results.push_back(script[i].res);
                end else begin
                    push_predicted();
                end
            end
        end

        // Random phases: mostly well-formed sequences with random echoes, some noise.
        foreach (wait_settings[p]) begin
            wait_drained();
            write_wait_ticks(wait_settings[p]);
            quota = 130 + int'(wait_settings[p]);
            sent  = 0;
            while (sent < quota) begin
                if (sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    it.kind      = 1'($urandom_range(0, 1));
                    it.echo_byte = 8'($urandom_range(0, 255));
                end else if (slot_busy) begin
                    it.kind = ows_pkg::KIND_DONE;
                    r = $urandom_range(0, 99);
                    if (r < 45) it.echo_byte = ECHO_ONE;
                    else if (r < 80) it.echo_byte = 8'h00;
                    else it.echo_byte = 8'($urandom_range(0, 255));
                    sent++;
                end else begin
                    it.kind      = ows_pkg::KIND_TICK;
                    it.echo_byte = 8'($urandom_range(0, 255));
                    sent++;
                end
                offer_item(it, tx_calm ? 0 : draw_gap());
                push_predicted();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
